// ===== hw/rtl/spiral_order_reader_top_defines.svh =====
// Assertion macros for the spiral order reader checker.
`ifndef SPIRAL_ORDER_READER_TOP_DEFINES_SVH
`define SPIRAL_ORDER_READER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SOR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spiral order reader check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SOR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spiral order reader check failed");

`endif

// ===== hw/rtl/sor_pkg.sv =====
// Package with the shared types and constants of the spiral order reader.
package sor_pkg;

  localparam int DATA_W     = 32;
  localparam int CFG_DATA_W = 4;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // store the accepted element and advance the load count
    logic init_walk;  // set up the bounds for a new spiral
    logic step;       // read one element and move one place along the spiral
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_done;  // the element now on the input completes the matrix
    logic walk_last;  // the current step reads the final element
  } dp_status_t;

  // A count of zero is used as one, a count above the maximum as the maximum.
  function automatic logic [CFG_DATA_W-1:0] clamp_count(input logic [CFG_DATA_W-1:0] v,
                                                        input logic [CFG_DATA_W-1:0] maxv);
    logic [CFG_DATA_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = CFG_DATA_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/sor_datapath.sv =====
// Datapath: configuration registers, element store and spiral address walker.
module sor_datapath #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sor_pkg::dp_cmd_t                  cmd,
  output sor_pkg::dp_status_t               status,
  input  logic signed [sor_pkg::DATA_W-1:0] in_element_value,
  input  logic                              cfg_valid,
  input  logic [sor_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sor_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              out_valid,
  output logic signed [sor_pkg::DATA_W-1:0] out_value,
  output logic                              out_last_of_run
);
  import sor_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LCW   = $clog2(DEPTH + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  logic [CFG_DATA_W-1:0] row_count_r, row_count_nxt;
  logic [CFG_DATA_W-1:0] column_count_r, column_count_nxt;
  logic [LCW-1:0]        load_count_r, load_count_nxt;

  logic [RW-1:0]  rows_eff;
  logic [CW-1:0]  cols_eff;
  logic [LCW-1:0] total_eff;
  logic [LCW-1:0] load_count_inc;

  logic [CW-1:0]  cols_r, cols_nxt;
  logic [LCW-1:0] total_r, total_nxt;
  logic [LCW-1:0] emit_cnt_r, emit_cnt_nxt;
  logic [1:0]     dir_r, dir_nxt;
  logic [RW-1:0]  r_r, r_nxt, top_r, top_nxt, bot_r, bot_nxt;
  logic [CW-1:0]  c_r, c_nxt, lft_r, lft_nxt, rgt_r, rgt_nxt;

  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] store_mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_last_r, out_last_nxt;

  assign rows_eff       = RW'(clamp_count(row_count_r, CFG_DATA_W'(MAX_ROWS)));
  assign cols_eff       = CW'(clamp_count(column_count_r, CFG_DATA_W'(MAX_COLS)));
  assign total_eff      = LCW'(rows_eff) * LCW'(cols_eff);
  assign load_count_inc = load_count_r + LCW'(1);

  assign status.load_done = (load_count_inc >= total_eff);
  assign status.walk_last = (emit_cnt_r == total_r - LCW'(1));

  // Row-major address of the current spiral position.
  assign rd_addr = AW'(LCW'(r_r) * LCW'(cols_r) + LCW'(c_r));

  always_comb begin
    row_count_nxt    = row_count_r;
    column_count_nxt = column_count_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    row_count_nxt    = cfg_data;
        REG_COLUMN_COUNT: column_count_nxt = cfg_data;
        default:          ;
      endcase
    end

    load_count_nxt = load_count_r;
    if (cmd.load) begin
      load_count_nxt = status.load_done ? '0 : load_count_inc;
    end

    cols_nxt     = cols_r;
    total_nxt    = total_r;
    emit_cnt_nxt = emit_cnt_r;
    dir_nxt      = dir_r;
    r_nxt        = r_r;
    c_nxt        = c_r;
    top_nxt      = top_r;
    bot_nxt      = bot_r;
    lft_nxt      = lft_r;
    rgt_nxt      = rgt_r;

    if (cmd.init_walk) begin
      cols_nxt     = cols_eff;
      total_nxt    = total_eff;
      emit_cnt_nxt = '0;
      dir_nxt      = DIR_RIGHT;
      r_nxt        = '0;
      c_nxt        = '0;
      top_nxt      = '0;
      bot_nxt      = rows_eff - RW'(1);
      lft_nxt      = '0;
      rgt_nxt      = cols_eff - CW'(1);
    end else if (cmd.step) begin
      emit_cnt_nxt = emit_cnt_r + LCW'(1);
      // At the end of a side the bound just passed moves inward and the walk turns.
      unique case (dir_r)
        DIR_RIGHT: begin
          if (c_r == rgt_r) begin
            top_nxt = top_r + RW'(1);
            r_nxt   = r_r + RW'(1);
            dir_nxt = DIR_DOWN;
          end else begin
            c_nxt = c_r + CW'(1);
          end
        end
        DIR_DOWN: begin
          if (r_r == bot_r) begin
            rgt_nxt = rgt_r - CW'(1);
            c_nxt   = c_r - CW'(1);
            dir_nxt = DIR_LEFT;
          end else begin
            r_nxt = r_r + RW'(1);
          end
        end
        DIR_LEFT: begin
          if (c_r == lft_r) begin
            bot_nxt = bot_r - RW'(1);
            r_nxt   = r_r - RW'(1);
            dir_nxt = DIR_UP;
          end else begin
            c_nxt = c_r - CW'(1);
          end
        end
        DIR_UP: begin
          if (r_r == top_r) begin
            lft_nxt = lft_r + CW'(1);
            c_nxt   = c_r + CW'(1);
            dir_nxt = DIR_RIGHT;
          end else begin
            r_nxt = r_r - RW'(1);
          end
        end
        default: ;
      endcase
    end

    out_valid_nxt = cmd.step;
    out_last_nxt  = cmd.step & status.walk_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= CFG_DATA_W'(MAX_ROWS);
      column_count_r <= CFG_DATA_W'(MAX_COLS);
      load_count_r   <= '0;
      out_valid_r    <= 1'b0;
      out_last_r     <= 1'b0;
      emit_cnt_r     <= '0;
      dir_r          <= DIR_RIGHT;
    end else begin
      row_count_r    <= row_count_nxt;
      column_count_r <= column_count_nxt;
      load_count_r   <= load_count_nxt;
      out_valid_r    <= out_valid_nxt;
      out_last_r     <= out_last_nxt;
      emit_cnt_r     <= emit_cnt_nxt;
      dir_r          <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cols_r  <= cols_nxt;
    total_r <= total_nxt;
    r_r     <= r_nxt;
    c_r     <= c_nxt;
    top_r   <= top_nxt;
    bot_r   <= bot_nxt;
    lft_r   <= lft_nxt;
    rgt_r   <= rgt_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      store_mem[load_count_r[AW-1:0]] <= in_element_value;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= store_mem[rd_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_value       = rd_data_r;
  assign out_last_of_run = out_last_r;

endmodule

// ===== hw/rtl/sor_ctrl.sv =====
// Controller: accepts elements and sequences the spiral read-out.
module sor_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output sor_pkg::dp_cmd_t    cmd,
  input  sor_pkg::dp_status_t status
);
  import sor_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic state_r, state_nxt;
  logic accept;

  assign busy   = (state_r == ST_WALK);
  assign accept = start & ~busy;

  always_comb begin
    state_nxt     = state_r;
    cmd.load      = accept;
    cmd.init_walk = accept & status.load_done;
    cmd.step      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && status.load_done) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (status.walk_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/spiral_order_reader_top.sv =====
// Spiral order reader: loads a matrix row-major and reads it back in clockwise spiral order.
//
// Input: an element transaction is taken at a rising edge with start high and busy low.
// Elements arrive in row-major order and are stored as they are taken.
// The rows*cols-th element starts the read-out: busy stays high while
// the address walker steps once per cycle through the element store, one read a cycle.
// Each result is shown for one cycle with out_valid high, in the cycle after its read,
// since out_value and out_valid are registered; the last result carries out_last_of_run.
// The receiver cannot stall; results must be taken as they come.
// Configuration: cfg_index 0 is the row count, 1 the column count; cfg_ready is always
// high. A count of zero acts as one and a count above the maximum as the maximum.
// Counts are read per element, so change them only between matrices.
// Reset (synchronous, rst_n low) sets both counts to their maximum and the load count
// to zero. The element store is not cleared; only elements of the current load are read.
module spiral_order_reader_top #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [sor_pkg::DATA_W-1:0] in_element_value,
  output logic                              out_valid,
  output logic signed [sor_pkg::DATA_W-1:0] out_value,
  output logic                              out_last_of_run,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sor_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sor_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sor_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  sor_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  sor_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_element_value (in_element_value),
    .cfg_valid        (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_value        (out_value),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

// ===== hw/rtl/sor_checker.sv =====
// Port-level checker for the spiral order reader, bound to the top level.
`include "spiral_order_reader_top_defines.svh"

module sor_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_last_of_run
);

  // A result is only produced by a read issued while the read-out was running.
  `SOR_ASSERT_SAME(a_result_follows_busy, clk, rst_n, out_valid, $past(busy))
  // The last flag never appears without a result.
  `SOR_ASSERT_SAME(a_last_has_valid, clk, rst_n, out_last_of_run, out_valid)
  // The read-out ends exactly when the last result is shown.
  `SOR_ASSERT_SAME(a_busy_falls_on_last, clk, rst_n, $fell(busy),
                   out_valid && out_last_of_run)
  // After a result that is not the last, the read-out still runs.
  `SOR_ASSERT_SAME(a_mid_result_busy, clk, rst_n, out_valid && !out_last_of_run, busy)

endmodule

bind spiral_order_reader_top sor_checker u_sor_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_last_of_run (out_last_of_run)
);
